// ----- sv/fits_header_card_parser_macros.svh -----
// Assertion macros for the header card parser.
// Used by fits_header_card_parser.sv; needs no package.
`ifndef FITS_HEADER_CARD_PARSER_MACROS_SVH
`define FITS_HEADER_CARD_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define FHCP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define FHCP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fhcp_pkg.sv -----
// Shared constants, codes and types of the header card parser.
// No dependencies; compile first.
`timescale 1ns / 1ps

package fhcp_pkg;

    localparam int KEY_LEN_DEF  = 8;
    localparam int CARD_LEN_DEF = 80;

    localparam int CHAR_W    = 8;
    localparam int POS_W     = 7;
    localparam int SP_W      = 7;
    localparam int KW_W      = 64;
    localparam int KLEN_W    = 4;
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;

    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [SP_W-1:0] SP_MAX = '1;

    typedef enum logic [1:0] {
        KIND_KEYWORD = 2'd0,
        KIND_VALUE   = 2'd1,
        KIND_COMMENT = 2'd2,
        KIND_END     = 2'd3
    } item_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2
    } card_status_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [KW_W-1:0]     kw_text;
        logic [KLEN_W-1:0]   kw_len;
        logic [CHAR_W-1:0]   text_char;
        logic [SP_W-1:0]     spaces;
        card_status_t        status;
        logic                last;
    } result_t;

    // Results caused by one card character, in order, with their count.
    typedef struct packed {
        logic [RES_CNT_W-1:0]      count;
        result_t [MAX_RES-1:0]     res;
    } res_set_t;

    typedef struct packed {
        logic                 room;
        logic [RES_CNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic advance;
    } core_stat_t;

endpackage

// ----- sv/fhcp_in_if.sv -----
// Input channel: one card character per transfer.
// Depends on fhcp_pkg.
`timescale 1ns / 1ps

interface fhcp_in_if import fhcp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] card_char;
    logic              card_last;

    modport source (output valid, output card_char, output card_last, input ready);
    modport sink   (input valid, input card_char, input card_last, output ready);

endinterface

// ----- sv/fhcp_out_if.sv -----
// Output channel: one parse result per transfer.
// Depends on fhcp_pkg.
`timescale 1ns / 1ps

interface fhcp_out_if import fhcp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [1:0]        item_kind;
    logic [KW_W-1:0]   keyword_text;
    logic [KLEN_W-1:0] keyword_length;
    logic [CHAR_W-1:0] text_char;
    logic [SP_W-1:0]   spaces_before;
    logic [1:0]        card_status;
    logic              result_last;

    modport source (
        output valid, output item_kind, output keyword_text, output keyword_length,
        output text_char, output spaces_before, output card_status, output result_last,
        input ready
    );
    modport sink (
        input valid, input item_kind, input keyword_text, input keyword_length,
        input text_char, input spaces_before, input card_status, input result_last,
        output ready
    );

endinterface

// ----- sv/fhcp_kw_trim.sv -----
// Keyword trim and pack: strips leading and trailing spaces, packs first byte highest.
// Depends on fhcp_pkg.
`timescale 1ns / 1ps

module fhcp_kw_trim import fhcp_pkg::*; #(
    parameter int KEY_LEN = KEY_LEN_DEF
) (
    input  logic [KEY_LEN-1:0][CHAR_W-1:0] key_bytes,
    output logic [KW_W-1:0]                kw_text,
    output logic [KLEN_W-1:0]              kw_len
);

    logic [KW_W-1:0]   vec;
    logic [KW_W-1:0]   shifted;
    logic [KW_W-1:0]   mask;
    logic [KLEN_W-1:0] lead;
    logic [KLEN_W-1:0] tail_end;
    logic [KLEN_W-1:0] len;
    logic              any;

    always_comb
    begin
        vec      = '0;
        lead     = KLEN_W'(KEY_LEN);
        tail_end = '0;
        any      = 1'b0;
        for (int i = 0; i < KEY_LEN; i++)
        begin
            vec[KW_W-1-CHAR_W*i -: CHAR_W] = key_bytes[i];
            if (key_bytes[i] != CH_SPACE)
            begin
                tail_end = KLEN_W'(i + 1);
                any      = 1'b1;
            end
        end
        for (int i = KEY_LEN - 1; i >= 0; i--)
        begin
            if (key_bytes[i] != CH_SPACE)
                lead = KLEN_W'(i);
        end
        len     = any ? (tail_end - lead) : '0;
        // drop leading spaces, then keep only the trimmed bytes
        shifted = vec << {lead, 3'b000};
        mask    = ~({KW_W{1'b1}} >> {len, 3'b000});
        kw_text = shifted & mask;
        kw_len  = len;
    end

endmodule

// ----- sv/fhcp_core.sv -----
// Input register, card state and per-character parse decision.
// Depends on fhcp_pkg, fhcp_in_if and fhcp_kw_trim.
`timescale 1ns / 1ps

module fhcp_core import fhcp_pkg::*; #(
    parameter int KEY_LEN  = KEY_LEN_DEF,
    parameter int CARD_LEN = CARD_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fhcp_in_if.sink    card_in,
    input  q_stat_t    q_stat,
    output res_set_t   res_set,
    output core_stat_t stat
);

    typedef enum logic [1:0] {
        MODE_KEYWORD = 2'd0,
        MODE_VALUE   = 2'd1,
        MODE_COMMENT = 2'd2
    } field_mode_t;

    localparam logic [POS_W-1:0] POS_KEY    = POS_W'(KEY_LEN);
    localparam logic [POS_W-1:0] POS_KEY_M1 = POS_W'(KEY_LEN - 1);
    localparam logic [POS_W-1:0] POS_KEY_P1 = POS_W'(KEY_LEN + 1);
    localparam logic [POS_W-1:0] POS_CARD   = POS_W'(CARD_LEN);

    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    field_mode_t       mode_reg, mode_next;
    logic [SP_W-1:0]   ps_reg,   ps_next;
    logic              fs_reg,   fs_next;

    logic [KEY_LEN-1:0][CHAR_W-1:0] kw_store_reg;
    logic [KEY_LEN-1:0][CHAR_W-1:0] kw_view;
    logic [CHAR_W-1:0]              held0_reg;

    logic [KW_W-1:0]   kw_text;
    logic [KLEN_W-1:0] kw_len;

    logic                  advance;
    logic [RES_CNT_W-1:0]  cnt;
    result_t [MAX_RES-1:0] res;

    function automatic result_t mk_kw(input logic [KW_W-1:0] t, input logic [KLEN_W-1:0] l);
        result_t r;
        r         = '0;
        r.kind    = KIND_KEYWORD;
        r.kw_text = t;
        r.kw_len  = l;
        return r;
    endfunction

    function automatic result_t mk_text(input item_kind_t k, input logic [CHAR_W-1:0] ch,
                                        input logic [SP_W-1:0] sp);
        result_t r;
        r           = '0;
        r.kind      = k;
        r.text_char = ch;
        r.spaces    = sp;
        return r;
    endfunction

    function automatic result_t mk_end(input card_status_t st);
        result_t r;
        r        = '0;
        r.kind   = KIND_END;
        r.status = st;
        return r;
    endfunction

    // advance the held character whenever the result queue can take its results
    assign advance       = in_vld_reg && q_stat.room;
    assign card_in.ready = !in_vld_reg || advance;
    assign stat.busy     = in_vld_reg;
    assign stat.advance  = advance;

    // keyword bytes including the character being written this cycle
    always_comb
    begin
        for (int i = 0; i < KEY_LEN; i++)
            kw_view[i] = (pos_reg == POS_W'(i)) ? in_char_reg : kw_store_reg[i];
    end

    fhcp_kw_trim #(
        .KEY_LEN (KEY_LEN)
    ) u_kw_trim (
        .key_bytes (kw_view),
        .kw_text   (kw_text),
        .kw_len    (kw_len)
    );

    always_comb
    begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        ps_next   = ps_reg;
        fs_next   = fs_reg;
        cnt       = '0;
        res       = '0;

        if (pos_reg >= POS_CARD)
        begin
            if (in_last_reg)
            begin
                res[cnt] = mk_end(ST_LONG);
                cnt      = cnt + 2'd1;
            end
        end
        else if (pos_reg < POS_KEY)
        begin
            if (in_last_reg)
            begin
                if (pos_reg < POS_KEY_M1)
                begin
                    res[cnt] = mk_end(ST_SHORT);
                    cnt      = cnt + 2'd1;
                end
                else
                begin
                    res[cnt] = mk_kw(kw_text, kw_len);
                    cnt      = cnt + 2'd1;
                    res[cnt] = mk_end(ST_OK);
                    cnt      = cnt + 2'd1;
                end
            end
        end
        else if (pos_reg == POS_KEY)
        begin
            if (in_last_reg)
            begin
                res[cnt] = mk_kw(kw_text, kw_len);
                cnt      = cnt + 2'd1;
                res[cnt] = mk_end(ST_OK);
                cnt      = cnt + 2'd1;
            end
        end
        else if (pos_reg == POS_KEY_P1)
        begin
            if (in_last_reg)
            begin
                res[cnt] = mk_kw(kw_text, kw_len);
                cnt      = cnt + 2'd1;
                res[cnt] = mk_end(ST_OK);
                cnt      = cnt + 2'd1;
            end
            else
            begin
                ps_next = '0;
                fs_next = 1'b0;
                if (held0_reg == CH_EQUAL && in_char_reg == CH_SPACE)
                begin
                    mode_next = MODE_VALUE;
                    res[cnt]  = mk_kw(kw_text, kw_len);
                    cnt       = cnt + 2'd1;
                end
                else
                begin
                    // no value: empty keyword, comment starts at the held character
                    mode_next = MODE_COMMENT;
                    res[cnt]  = mk_kw('0, '0);
                    cnt       = cnt + 2'd1;
                    if (held0_reg != CH_SPACE)
                    begin
                        res[cnt] = mk_text(KIND_COMMENT, held0_reg, '0);
                        cnt      = cnt + 2'd1;
                        fs_next  = 1'b1;
                    end
                    if (in_char_reg == CH_SPACE)
                    begin
                        if (fs_next)
                            ps_next = SP_W'(1);
                    end
                    else
                    begin
                        res[cnt] = mk_text(KIND_COMMENT, in_char_reg, '0);
                        cnt      = cnt + 2'd1;
                        fs_next  = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (mode_reg == MODE_VALUE && in_char_reg == CH_SLASH)
            begin
                mode_next = MODE_COMMENT;
                ps_next   = '0;
                fs_next   = 1'b0;
            end
            else if (in_char_reg == CH_SPACE)
            begin
                if (fs_reg && ps_reg != SP_MAX)
                    ps_next = ps_reg + SP_W'(1);
            end
            else
            begin
                res[cnt] = mk_text((mode_reg == MODE_VALUE) ? KIND_VALUE : KIND_COMMENT,
                                   in_char_reg, ps_reg);
                cnt      = cnt + 2'd1;
                ps_next  = '0;
                fs_next  = 1'b1;
            end
            if (in_last_reg)
            begin
                res[cnt] = mk_end(ST_OK);
                cnt      = cnt + 2'd1;
            end
        end

        if (in_last_reg)
        begin
            pos_next  = '0;
            mode_next = MODE_KEYWORD;
            ps_next   = '0;
            fs_next   = 1'b0;
        end
        else if (pos_reg < POS_CARD)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        for (int i = 0; i < MAX_RES; i++)
            res[i].last = (cnt != '0) && (RES_CNT_W'(i) == cnt - 2'd1);

        res_set.count = cnt;
        res_set.res   = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            pos_reg    <= '0;
            mode_reg   <= MODE_KEYWORD;
            ps_reg     <= '0;
            fs_reg     <= 1'b0;
        end
        else
        begin
            if (card_in.ready)
                in_vld_reg <= card_in.valid;
            if (advance)
            begin
                pos_reg  <= pos_next;
                mode_reg <= mode_next;
                ps_reg   <= ps_next;
                fs_reg   <= fs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (card_in.valid && card_in.ready)
        begin
            in_char_reg <= card_in.card_char;
            in_last_reg <= card_in.card_last;
        end
        if (advance)
        begin
            kw_store_reg <= kw_view;
            if (pos_reg == POS_KEY)
                held0_reg <= in_char_reg;
        end
    end

endmodule

// ----- sv/fhcp_result_queue.sv -----
// Result register queue: holds up to three results of one character, drains one per cycle while the output is ready.
// Depends on fhcp_pkg and fhcp_out_if.
`timescale 1ns / 1ps

module fhcp_result_queue import fhcp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_set_t    res_set,
    output q_stat_t     q_stat,
    fhcp_out_if.source  result_out
);

    result_t [MAX_RES-1:0]  slot_reg;
    logic [RES_CNT_W-1:0]   count_reg;
    logic                   pop;

    assign result_out.valid = (count_reg != '0);
    assign pop              = result_out.valid && result_out.ready;

    assign q_stat.room  = (count_reg == '0) || (count_reg == RES_CNT_W'(1) && pop);
    assign q_stat.count = count_reg;

    assign result_out.item_kind      = slot_reg[0].kind;
    assign result_out.keyword_text   = slot_reg[0].kw_text;
    assign result_out.keyword_length = slot_reg[0].kw_len;
    assign result_out.text_char      = slot_reg[0].text_char;
    assign result_out.spaces_before  = slot_reg[0].spaces;
    assign result_out.card_status    = slot_reg[0].status;
    assign result_out.result_last    = slot_reg[0].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (load)
            count_reg <= res_set.count;
        else if (pop)
            count_reg <= count_reg - RES_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= res_set.res;
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

// ----- sv/fits_header_card_parser.sv -----
// Header card parser: one character per transfer in, keyword/value/comment records out.
// Each character transfer is captured in an input register; the parse decision for it is
// made in one pass against the card state and lands in a three-entry result register
// queue, which drains one result per cycle while the output is ready. A character with
// at most one result frees the input register when it is loaded, so plain value and
// comment text streams at one character per clock while the output is ready. A character
// with k results (keyword record plus card end, or keyword record plus up to two comment
// characters at the keyword boundary) holds the input register while the queue drains.
// Its first result is offered once its result set is loaded into the queue, and output
// stalls back up through the queue and the input register. Depends on fhcp_pkg, the two
// channel interfaces, fhcp_core, fhcp_result_queue and the assertion macro header.
`timescale 1ns / 1ps
`include "fits_header_card_parser_macros.svh"

module fits_header_card_parser import fhcp_pkg::*; #(
    parameter int KEY_LEN  = KEY_LEN_DEF,
    parameter int CARD_LEN = CARD_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fhcp_in_if.sink    card_in,
    fhcp_out_if.source result_out
);

    res_set_t   res_set;
    q_stat_t    q_stat;
    core_stat_t core_stat;

    // Parse stage: input register, card position, field mode and space counters.
    fhcp_core #(
        .KEY_LEN  (KEY_LEN),
        .CARD_LEN (CARD_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .card_in (card_in),
        .q_stat  (q_stat),
        .res_set (res_set),
        .stat    (core_stat)
    );

    // Result stage: load a whole result set when the parse stage advances, drain in order.
    fhcp_result_queue u_result_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (core_stat.advance),
        .res_set    (res_set),
        .q_stat     (q_stat),
        .result_out (result_out)
    );

    // A card end always closes the result set of its character.
    `FHCP_ASSERT_IMPL(a_end_is_last, clk, rst_n,
        result_out.valid && result_out.item_kind == KIND_END, result_out.result_last,
        "card end transfer not marked last")

    // Keyword fields stay clear on every other kind of result.
    `FHCP_ASSERT_IMPL(a_kw_clear, clk, rst_n,
        result_out.valid && result_out.item_kind != KIND_KEYWORD,
        result_out.keyword_text == '0 && result_out.keyword_length == '0,
        "keyword fields set on a non-keyword result")

    // The queue holds exactly the set loaded by the parse stage.
    `FHCP_ASSERT_NEXT(a_load_count, clk, rst_n, core_stat.advance,
        q_stat.count == $past(res_set.count), "result queue count differs from loaded set")

    // A held character with no room must not take a new transfer.
    `FHCP_ASSERT_IMPL(a_hold_input, clk, rst_n, core_stat.busy && !q_stat.room,
        !card_in.ready, "input taken while parse stage is blocked")

endmodule
